// File: hdl/escaped_frame_receiver_crc_check_assert.svh
// Assertion macros shared by the deframer RTL.
`ifndef ESCAPED_FRAME_RECEIVER_CRC_CHECK_ASSERT_SVH
`define ESCAPED_FRAME_RECEIVER_CRC_CHECK_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define EFR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define EFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/efr_pkg.sv
package efr_pkg;

  localparam int BUFFER_BYTES_DEFAULT = 30;
  localparam int HEADER_DEPTH = 7;
  localparam int HEADER_SIZE  = 6;
  localparam int PAYLOAD_W    = 5;

  localparam logic [7:0]  ESCAPE_BYTE = 8'd27;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h8408;

  // Register indexes on the configuration port
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOST_ADDRESS    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_CODE      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_END_CODE        = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ESC_ESCAPE_CODE = 2'd3;

  localparam logic [15:0] HOST_ADDRESS_RESET = 16'd0;
  localparam logic [7:0]  START_CODE_RESET   = 8'd2;
  localparam logic [7:0]  END_CODE_RESET     = 8'd3;
  localparam logic [7:0]  ESC_ESCAPE_RESET   = 8'd27;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] end_code;
    logic [7:0] escaped_escape_code;
  } codes_t;

  // Frame state as seen by the verdict logic
  typedef struct packed {
    logic [15:0]                        crc;
    logic                               long_enough;
    logic [PAYLOAD_W-1:0]               payload_count;
    logic                               has_command;
    logic [HEADER_DEPTH-1:0][7:0]       header;
  } frame_status_t;

  // Reflected CRC-16-CCITT, one byte
  function automatic logic [15:0] crc_step(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'd0, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/efr_frame_track.sv
// Escape decoding, byte count, running CRC and header capture.
module efr_frame_track import efr_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  input  logic [7:0]    rx_byte,
  input  codes_t        codes,
  output logic          end_hit,
  output frame_status_t status
);

  localparam int CW = $clog2(BUFFER_BYTES);

  logic          escape_pending;
  logic [CW-1:0] byte_count;
  logic [15:0]   running_crc;
  logic [HEADER_DEPTH-1:0][7:0] header_bytes;

  logic          is_start, is_end, is_esc_esc;
  logic          store;
  logic [7:0]    store_data;
  logic          restart;
  logic [CW:0]   count_inc;
  logic [CW:0]   payload_full;

  assign is_start   = escape_pending && (rx_byte == codes.start_code);
  assign is_end     = escape_pending && !is_start && (rx_byte == codes.end_code);
  assign is_esc_esc = escape_pending && !is_start && !is_end &&
                      (rx_byte == codes.escaped_escape_code);

  assign end_hit    = byte_valid && is_end;
  assign restart    = byte_valid && is_start;
  assign store      = byte_valid && (is_esc_esc || (!escape_pending && rx_byte != ESCAPE_BYTE));
  assign store_data = escape_pending ? ESCAPE_BYTE : rx_byte;
  assign count_inc  = {1'b0, byte_count} + (CW+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      byte_count     <= '0;
      running_crc    <= CRC_INIT;
    end else if (byte_valid) begin
      escape_pending <= !escape_pending && (rx_byte == ESCAPE_BYTE);
      if (restart) begin
        byte_count  <= '0;
        running_crc <= CRC_INIT;
      end else if (store) begin
        if (count_inc == (CW+1)'(BUFFER_BYTES)) begin
          byte_count  <= '0;
          running_crc <= CRC_INIT;
        end else begin
          byte_count  <= count_inc[CW-1:0];
          running_crc <= crc_step(running_crc, store_data);
        end
      end
    end
  end

  // Header is part of the frame state; it survives frame boundaries
  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes <= '0;
    end else begin
      for (int i = 0; i < HEADER_DEPTH; i++) begin
        if (store && byte_count == CW'(i)) begin
          header_bytes[i] <= store_data;
        end
      end
    end
  end

  // One spare bit so the payload field fits even for the smallest buffer
  assign payload_full = {1'b0, byte_count} - (CW+1)'(2);

  always_comb begin
    status.crc           = running_crc;
    status.long_enough   = byte_count >= CW'(3);
    status.payload_count = payload_full[PAYLOAD_W-1:0];
    status.has_command   = payload_full != (CW+1)'(HEADER_SIZE);
    status.header        = header_bytes;
  end

endmodule

// File: hdl/escaped_frame_receiver_crc_check.sv
// Channel  | Dir | Fields (low bit first)
// s_axis   | in  | tdata[7:0] rx_byte
// m_axis   | out | tdata: frame_good, addressed_here, ack_flag, frame_number[8],
//          |     |   sender_address[16], new_frame, payload_count[5],
//          |     |   command_byte[8], has_command, 6 zero bits
// cfg      | in  | cfg_we / cfg_index / cfg_data, no read-back
//
// One received byte per cycle while s_axis_tready is high; the escape decoder,
// CRC byte update and verdict are combinational between the frame state and the
// output register. A verdict appears on m_axis in the cycle after its end code.
// Only the end code after an escape produces an item.
// s_axis_tready drops only while a verdict sits unread in the output register.
// Reset (rst, synchronous) restores reset codes, CRC 0xFFFF, count and header 0.
module escaped_frame_receiver_crc_check import efr_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // Received bytes
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] rx_byte
  // Frame verdicts
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [47:0]            m_axis_tdata,   // [0] frame_good, [1] addressed_here,
                                                 // [2] ack_flag, [10:3] frame_number,
                                                 // [26:11] sender_address, [27] new_frame,
                                                 // [32:28] payload_count,
                                                 // [40:33] command_byte, [41] has_command
  // Configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data
);

  // Configuration registers
  logic [15:0] host_address;
  codes_t      codes;

  always_ff @(posedge clk) begin
    if (rst) begin
      host_address              <= HOST_ADDRESS_RESET;
      codes.start_code          <= START_CODE_RESET;
      codes.end_code            <= END_CODE_RESET;
      codes.escaped_escape_code <= ESC_ESCAPE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HOST_ADDRESS:    host_address              <= cfg_data;
        CFG_START_CODE:      codes.start_code          <= cfg_data[7:0];
        CFG_END_CODE:        codes.end_code            <= cfg_data[7:0];
        CFG_ESC_ESCAPE_CODE: codes.escaped_escape_code <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic          in_accept;
  logic          end_hit;
  frame_status_t status;

  // Output register frees up in the same cycle its item is taken
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  efr_frame_track #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_track (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(in_accept),
    .rx_byte   (s_axis_tdata[7:0]),
    .codes     (codes),
    .end_hit   (end_hit),
    .status    (status)
  );

  // Verdict from the frame state as it stands at the end code
  logic        good, here, fresh;
  logic [15:0] dest, src;
  logic [7:0]  frame_id;
  logic [7:0]  last_frame_number;
  logic [47:0] verdict;

  assign dest     = {status.header[1], status.header[0]};
  assign src      = {status.header[3], status.header[2]};
  assign frame_id = status.header[4];
  assign good     = status.long_enough && (status.crc == 16'd0);
  assign here     = good && (dest == host_address);
  assign fresh    = here && (frame_id != last_frame_number);

  always_comb begin
    verdict = '0;
    if (good) begin
      verdict = {6'd0,
                 status.has_command,
                 status.header[6],
                 status.payload_count,
                 fresh,
                 src,
                 frame_id,
                 status.header[5] != 8'd0,
                 here,
                 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_frame_number <= 8'd0;
    end else if (end_hit && fresh) begin
      last_frame_number <= frame_id;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (end_hit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_hit) begin
      m_axis_tdata <= verdict;
    end
  end

`include "escaped_frame_receiver_crc_check_assert.svh"

  `EFR_ASSERT_NOW(a_bad_frame_zero, clk, rst,
    m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[47:1] == 47'd0,
    "bad frame verdict carries nonzero fields")

  `EFR_ASSERT_NOW(a_new_implies_here, clk, rst,
    m_axis_tvalid && m_axis_tdata[27], m_axis_tdata[1] && m_axis_tdata[0],
    "new frame flagged on a frame not addressed here")

  `EFR_ASSERT_NEXT(a_last_id_tracks, clk, rst,
    end_hit && fresh, last_frame_number == m_axis_tdata[10:3],
    "last frame id not updated from a new frame")

  `EFR_ASSERT_NOW(a_has_command, clk, rst,
    m_axis_tvalid && m_axis_tdata[0],
    m_axis_tdata[41] == (m_axis_tdata[32:28] != 5'(HEADER_SIZE)) ||
    BUFFER_BYTES > 32,
    "has_command disagrees with payload count")

endmodule

// File: bench/tb_top.sv
// Bench for the escaped-frame receiver. Bytes go in on s_axis, frame verdicts come back
// on m_axis. A scoreboard predicts each verdict from the bytes as they are accepted, or takes
// one typed in beside the end byte, and compares each m_axis item field by field with the oldest.
module tb_top import efr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RX_BUFFER   = BUFFER_BYTES_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;

  // One verdict as packed on m_axis_tdata, frame_good in bit 0
  typedef struct packed {
    logic       has_command;
    logic [7:0] command_byte;
    logic [4:0] payload_count;
    logic       new_frame;
    logic [15:0] sender_address;
    logic [7:0] frame_number;
    logic       ack_flag;
    logic       addressed_here;
    logic       frame_good;
  } verdict_t;

  // Directed table: what each row puts on the line
  typedef enum logic [2:0] {
    ROW_RAW,    // one byte exactly as given
    ROW_DATA,   // one stored byte, escaped if it is the escape byte
    ROW_START,  // escape + start code
    ROW_END,    // escape + end code, verdict optionally typed in
    ROW_FCS     // two check bytes over the data since the last start
  } row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [7:0] value;
    bit         pinned;
    verdict_t   want;
  } row_t;

  // One configuration phase of the random part
  typedef struct {
    logic [15:0] host;
    logic [7:0]  start_code;
    logic [7:0]  end_code;
    logic [7:0]  esc_code;
    int          budget;
    int          gap_pct;
    int          stall_pct;
  } setting_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata;    // [7:0] rx_byte
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [47:0] m_axis_tdata;   // [0] frame_good, [1] addressed_here, [2] ack_flag,
                               // [10:3] frame_number, [26:11] sender_address,
                               // [27] new_frame, [32:28] payload_count,
                               // [40:33] command_byte, [41] has_command
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [15:0] cfg_data;

  // Typed-in verdict travels alongside the byte that ends the frame
  logic     pin_valid;
  verdict_t pin_verdict;

  escaped_frame_receiver_crc_check uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Receiver model: own copy of link state and registers
  // ---------------------------------------------------------------------------
  logic [15:0] rx_host;
  logic [7:0]  rx_start_code;
  logic [7:0]  rx_end_code;
  logic [7:0]  rx_esc_code;
  logic        rx_in_escape;
  int          rx_count;
  logic [15:0] rx_crc;
  logic [7:0]  rx_head [HEADER_DEPTH];
  logic [7:0]  rx_last_id;

  verdict_t verdict_q [$];
  int       failures = 0;

  // Reflected CCITT, one data bit at a time
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic void rx_reset();
    rx_host       = HOST_ADDRESS_RESET;
    rx_start_code = START_CODE_RESET;
    rx_end_code   = END_CODE_RESET;
    rx_esc_code   = ESC_ESCAPE_RESET;
    rx_in_escape  = 1'b0;
    rx_count      = 0;
    rx_crc        = CRC_INIT;
    rx_last_id    = 8'd0;
    foreach (rx_head[i]) rx_head[i] = 8'd0;
  endfunction

  function automatic void rx_write_reg(input logic [CFG_INDEX_W-1:0] idx,
                                       input logic [15:0] val);
    case (idx)
      CFG_HOST_ADDRESS:    rx_host = val;
      CFG_START_CODE:      rx_start_code = val[7:0];
      CFG_END_CODE:        rx_end_code = val[7:0];
      CFG_ESC_ESCAPE_CODE: rx_esc_code = val[7:0];
      default: ;
    endcase
  endfunction

  function automatic void rx_store(input logic [7:0] b);
    if (rx_count < HEADER_DEPTH) rx_head[rx_count] = b;
    rx_crc = crc_byte(rx_crc, b);
    rx_count++;
    // buffer wrap restarts count and CRC
    if (rx_count >= RX_BUFFER) begin
      rx_count = 0;
      rx_crc = CRC_INIT;
    end
  endfunction

  function automatic verdict_t rx_verdict();
    verdict_t v;
    logic [15:0] dest;
    int pay;
    v = '0;
    // bad frame: everything else stays zero
    if (rx_count < 3 || rx_crc != 16'd0) return v;
    dest = {rx_head[1], rx_head[0]};
    pay = rx_count - 2;
    v.frame_good     = 1'b1;
    v.addressed_here = (dest == rx_host);
    v.ack_flag       = (rx_head[5] != 8'd0);
    v.frame_number   = rx_head[4];
    v.sender_address = {rx_head[3], rx_head[2]};
    v.new_frame      = v.addressed_here && (rx_head[4] != rx_last_id);
    v.payload_count  = pay[4:0];
    v.command_byte   = rx_head[6];
    v.has_command    = (pay != HEADER_SIZE);
    if (v.new_frame) rx_last_id = rx_head[4];
    return v;
  endfunction

  // Returns 1 when the byte ends a frame; the verdict goes out through v
  function automatic bit rx_take(input logic [7:0] c, output verdict_t v);
    v = '0;
    if (rx_in_escape) begin
      rx_in_escape = 1'b0;
      // start beats end beats escaped escape; anything else is dropped
      if (c == rx_start_code) begin
        rx_count = 0;
        rx_crc = CRC_INIT;
      end else if (c == rx_end_code) begin
        v = rx_verdict();
        return 1'b1;
      end else if (c == rx_esc_code) begin
        rx_store(ESCAPE_BYTE);
      end
      return 1'b0;
    end
    if (c == ESCAPE_BYTE) begin
      rx_in_escape = 1'b1;
    end else begin
      rx_store(c);
    end
    return 1'b0;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard: predict on accepted bytes and register writes, then check verdicts
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    verdict_t pred;
    verdict_t want;
    verdict_t got;
    if (rst) begin
      rx_reset();
      verdict_q.delete();
    end else begin
      if (cfg_we) rx_write_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready) begin
        if (rx_take(s_axis_tdata, pred)) verdict_q.push_back(pin_valid ? pin_verdict : pred);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = verdict_t'(m_axis_tdata[41:0]);
        if (verdict_q.size() == 0) begin
          $error("verdict with nothing expected: tdata 0x%0h", m_axis_tdata);
          failures++;
        end else begin
          want = verdict_q.pop_front();
          check_field("frame_good", want.frame_good, got.frame_good);
          check_field("addressed_here", want.addressed_here, got.addressed_here);
          check_field("ack_flag", want.ack_flag, got.ack_flag);
          check_field("frame_number", want.frame_number, got.frame_number);
          check_field("sender_address", want.sender_address, got.sender_address);
          check_field("new_frame", want.new_frame, got.new_frame);
          check_field("payload_count", want.payload_count, got.payload_count);
          check_field("command_byte", want.command_byte, got.command_byte);
          check_field("has_command", want.has_command, got.has_command);
          check_field("tdata pad", 0, m_axis_tdata[47:42]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Verdict side backpressure: random stall bursts at stall_pct
  // ---------------------------------------------------------------------------
  int gap_pct   = 0;
  int stall_pct = 0;

  initial begin : sink_stalls
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Line driver
  // ---------------------------------------------------------------------------
  logic [15:0] line_host  = HOST_ADDRESS_RESET;
  logic [7:0]  line_start = START_CODE_RESET;
  logic [7:0]  line_end   = END_CODE_RESET;
  logic [7:0]  line_esc   = ESC_ESCAPE_RESET;
  logic [15:0] line_fcs   = CRC_INIT;
  int          sent_items = 0;

  task automatic push_byte(input logic [7:0] b, input bit pin = 1'b0,
                           input verdict_t want = '0);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    pin_valid     <= pin;
    pin_verdict   <= want;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_data(input logic [7:0] b);
    line_fcs = crc_byte(line_fcs, b);
    if (b == ESCAPE_BYTE) begin
      push_byte(ESCAPE_BYTE);
      push_byte(line_esc);
    end else begin
      push_byte(b);
    end
  endtask

  task automatic send_start();
    line_fcs = CRC_INIT;
    push_byte(ESCAPE_BYTE);
    push_byte(line_start);
  endtask

  task automatic send_end(input bit pin = 1'b0, input verdict_t want = '0);
    push_byte(ESCAPE_BYTE);
    push_byte(line_end, pin, want);
  endtask

  // Check bytes go out low first; the receiver residue is then zero
  task automatic send_fcs();
    logic [15:0] fcs;
    fcs = line_fcs;
    send_data(fcs[7:0]);
    send_data(fcs[15:8]);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return ESCAPE_BYTE;
      1: return 8'h00;
      2: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Escape followed by a byte that is none of the three codes
  function automatic logic [7:0] stray_code();
    logic [7:0] c;
    c = 8'($urandom);
    while (c == line_start || c == line_end || c == line_esc) c = 8'($urandom);
    return c;
  endfunction

  // Mostly well-formed frames with random content; the rest broken or noise
  task automatic random_frame();
    int mode;
    int total;
    int flip_at;
    int stray_at;
    bit with_start;
    bit with_end;
    bit pre_wrap;
    logic [15:0] dest;
    logic [15:0] src;
    logic [15:0] fcs;
    logic [7:0]  head [HEADER_DEPTH];
    logic [7:0]  frame [$];
    logic [7:0]  b;
    mode = $urandom_range(0, 99);
    if (mode >= 95) begin
      // line noise
      repeat ($urandom_range(1, 8)) push_byte(pick_byte());
      return;
    end
    with_start = (mode < 90);
    with_end   = (mode < 85 || mode >= 90);
    pre_wrap   = (mode >= 68 && mode < 74);
    flip_at    = -1;
    stray_at   = -1;
    if ($urandom_range(0, 5) == 0) begin
      total = $urandom_range(13, 29);
    end else begin
      total = $urandom_range(3, 12);
    end
    if (mode >= 74 && mode < 79) total = $urandom_range(0, 2);
    dest = ($urandom_range(0, 3) != 0) ? line_host : 16'($urandom);
    src  = 16'($urandom);
    head[0] = dest[7:0];
    head[1] = dest[15:8];
    head[2] = src[7:0];
    head[3] = src[15:8];
    head[4] = 8'($urandom_range(0, 3));
    head[5] = $urandom_range(0, 1) ? 8'h00 : pick_byte();
    head[6] = pick_byte();
    if (total >= 2) begin
      fcs = CRC_INIT;
      for (int k = 0; k < total - 2; k++) begin
        b = (k < HEADER_DEPTH) ? head[k] : pick_byte();
        frame.push_back(b);
        fcs = crc_byte(fcs, b);
      end
      frame.push_back(fcs[7:0]);
      frame.push_back(fcs[15:8]);
    end else begin
      repeat (total) frame.push_back(pick_byte());
    end
    if (mode >= 60 && mode < 68 && total > 0) flip_at = $urandom_range(0, total - 1);
    if (mode >= 79 && mode < 85) stray_at = $urandom_range(0, total);
    if (with_start) send_start();
    // a full buffer of filler wraps the count back to zero before the frame
    if (pre_wrap) repeat (RX_BUFFER) send_data(pick_byte());
    foreach (frame[k]) begin
      if (k == stray_at) begin
        push_byte(ESCAPE_BYTE);
        push_byte(stray_code());
      end
      b = frame[k];
      if (k == flip_at) b[$urandom_range(0, 7)] = ~b[$urandom_range(0, 7)];
      send_data(b);
    end
    if (stray_at == total) begin
      push_byte(ESCAPE_BYTE);
      push_byte(stray_code());
    end
    if (with_end) send_end();
  endtask

  // Wait out every outstanding verdict with the input idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0 || m_axis_tvalid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_setting(input setting_t s);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HOST_ADDRESS;
    cfg_data  <= s.host;
    @(posedge clk);
    cfg_index <= CFG_START_CODE;
    cfg_data  <= {8'd0, s.start_code};
    @(posedge clk);
    cfg_index <= CFG_END_CODE;
    cfg_data  <= {8'd0, s.end_code};
    @(posedge clk);
    cfg_index <= CFG_ESC_ESCAPE_CODE;
    cfg_data  <= {8'd0, s.esc_code};
    @(posedge clk);
    cfg_we    <= 1'b0;
    line_host  = s.host;
    line_start = s.start_code;
    line_end   = s.end_code;
    line_esc   = s.esc_code;
  endtask

  // ---------------------------------------------------------------------------
  // Run watchdog
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  row_t     directed_rows [16];
  setting_t phase_plan [8];

  initial begin : stimulus
    int target;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    pin_valid     = 1'b0;
    pin_verdict   = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_HOST_ADDRESS;
    cfg_data      = 16'd0;

    // Reset codes throughout; zero verdicts are typed in, the rest predicted
    directed_rows = '{
      '{ROW_END,   8'h00, 1'b1, '0},  // end with nothing stored: bad
      '{ROW_START, 8'h00, 1'b0, '0},
      '{ROW_DATA,  8'h00, 1'b0, '0},  // dest 0 matches host after reset
      '{ROW_DATA,  8'h00, 1'b0, '0},
      '{ROW_FCS,   8'h00, 1'b0, '0},
      '{ROW_END,   8'h00, 1'b0, '0},  // good, short header, id 0 not new
      '{ROW_RAW,   8'h1B, 1'b0, '0},
      '{ROW_RAW,   8'h99, 1'b0, '0},  // unknown code is dropped
      '{ROW_START, 8'h00, 1'b0, '0},
      '{ROW_DATA,  8'h1B, 1'b0, '0},  // literal escape byte
      '{ROW_DATA,  8'hFF, 1'b0, '0},
      '{ROW_END,   8'h00, 1'b1, '0},  // two bytes only: bad
      '{ROW_END,   8'h00, 1'b1, '0},  // end keeps the count: still bad
      '{ROW_RAW,   8'hFF, 1'b0, '0},  // appended without a start
      '{ROW_RAW,   8'h00, 1'b0, '0},
      '{ROW_END,   8'h00, 1'b0, '0}
    };

    phase_plan = '{
      '{16'h1234, 8'h02, 8'h03, 8'h1B, 150, 25, 25},
      '{16'h0000, 8'h00, 8'hFF, 8'h80, 150, 10, 40},
      '{16'hFFFF, 8'hFF, 8'h00, 8'h01, 150, 40, 10},
      '{16'hA5C3, 8'h1B, 8'h2A, 8'h5C, 130,  0, 30},  // start code is the escape byte
      '{16'h0F0F, 8'h10, 8'h10, 8'h11,  60, 20, 20},  // start and end equal
      '{16'h7E81, 8'h05, 8'h06, 8'h06,  80, 20, 20},  // end and escaped escape equal
      '{16'h00FF, 8'h07, 8'h08, 8'h07,  80, 20, 20},  // start and escaped escape equal
      '{16'h8001, 8'h02, 8'h03, 8'h1B, 250,  0,  0}   // no idling at the end
    };

    gap_pct   = 20;
    stall_pct = 20;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      case (directed_rows[r].kind)
        ROW_RAW:   push_byte(directed_rows[r].value);
        ROW_DATA:  send_data(directed_rows[r].value);
        ROW_START: send_start();
        ROW_END:   send_end(directed_rows[r].pinned, directed_rows[r].want);
        ROW_FCS:   send_fcs();
        default: ;
      endcase
    end

    // Each phase starts idle: every verdict back before the registers change
    sent_items = 0;
    foreach (phase_plan[p]) begin
      settle();
      load_setting(phase_plan[p]);
      gap_pct   = phase_plan[p].gap_pct;
      stall_pct = phase_plan[p].stall_pct;
      target = sent_items + phase_plan[p].budget;
      while (sent_items < target) random_frame();
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
